// ----- hdl/mmd_pkg.sv -----
// -----------------------------------------------------------------------------
// mmd_pkg
// Shared constants and types of the min/max decimator: field widths, register
// reset value, scan length ceiling and the result item carried to the output.
// -----------------------------------------------------------------------------
package mmd_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int SCAN_W   = 12;

   // output point count default and scan length ceiling
   localparam int OUT_POINTS_DEF = 400;
   localparam int MAX_SCAN       = 4095;

   // scan length after reset
   localparam logic [SCAN_W-1:0] SCAN_LENGTH_RST = SCAN_W'(400);

   // cycles for the window size pipeline to settle after reset or a write
   localparam int SETTLE_CYCLES = 4;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   // number of results one sample can cause
   localparam int PUSH_W = 2;
   localparam logic [PUSH_W-1:0] PUSH_NONE = PUSH_W'(0);
   localparam logic [PUSH_W-1:0] PUSH_ONE  = PUSH_W'(1);
   localparam logic [PUSH_W-1:0] PUSH_TWO  = PUSH_W'(2);

   // one result item
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       end_of_run;
      logic                       scan_done;
   } rsp_item_type;

   // results handed from the window logic to the output queue
   typedef struct packed {
      logic [PUSH_W-1:0] count;
      rsp_item_type      first;
      rsp_item_type      second;
   } rsp_push_type;

endpackage

// ----- hdl/min_max_decimator_top.sv -----
// -----------------------------------------------------------------------------
// min_max_decimator_top
// A sample is held in the input register; its results then go into the result
// queue. Throughput: one sample per cycle, one result per cycle, while the
// queue has room, the output accepts and the window size pipeline has settled.
// Reset and every scan_length write clear the scan state; input then waits
// while the window size pipeline settles.
// -----------------------------------------------------------------------------
module min_max_decimator_top #(
   parameter int OUT_POINTS = mmd_pkg::OUT_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [15:0] sample
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [15:0] value
   output logic                          rsp_tlast,   // end_of_run
   output logic                          rsp_tuser,   // [0] scan_done
   // scan_length register
   input  logic                          csr_wen,
   input  logic [mmd_pkg::SCAN_W-1:0]    csr_wdata
);
   import mmd_pkg::*;

   localparam int LEN_W = $clog2(2 * MAX_SCAN / OUT_POINTS + 2);
   localparam int ACC_W = $clog2(OUT_POINTS);

   logic              pass_mode;
   logic [SCAN_W-1:0] scan_count;
   logic [LEN_W-1:0]  base_length;
   logic [ACC_W-1:0]  step_inc;
   logic              cfg_ready;
   logic              room;
   rsp_push_type      push;
   rsp_item_type      rsp_item;

   // window sizing from the scan length
   mmd_scale #(
      .OUT_POINTS (OUT_POINTS)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .pass_mode   (pass_mode),
      .scan_count  (scan_count),
      .base_length (base_length),
      .step_inc    (step_inc),
      .cfg_ready   (cfg_ready)
   );

   // per-sample min/max tracking
   mmd_window #(
      .OUT_POINTS (OUT_POINTS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_wen),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .pass_mode   (pass_mode),
      .scan_count  (scan_count),
      .base_length (base_length),
      .step_inc    (step_inc),
      .cfg_ready   (cfg_ready),
      .room        (room),
      .push        (push)
   );

   // result queue toward the output transfer
   mmd_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = rsp_item.value;
   assign rsp_tlast = rsp_item.end_of_run;
   assign rsp_tuser = rsp_item.scan_done;

endmodule

// ----- hdl/mmd_scale.sv -----
// -----------------------------------------------------------------------------
// mmd_scale
// Scan length register and window size unit: saturates the length, works out
// base = 2*count/OUT_POINTS by reciprocal multiply and the Bresenham step.
// -----------------------------------------------------------------------------
module mmd_scale #(
   parameter int OUT_POINTS = mmd_pkg::OUT_POINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [mmd_pkg::SCAN_W-1:0]  csr_wdata,
   output logic                        pass_mode,
   output logic [mmd_pkg::SCAN_W-1:0]  scan_count,
   output logic [$clog2(2 * mmd_pkg::MAX_SCAN / OUT_POINTS + 2)-1:0] base_length,
   output logic [$clog2(OUT_POINTS)-1:0] step_inc,
   output logic                        cfg_ready
);
   import mmd_pkg::*;

   localparam int LEN_W   = $clog2(2 * MAX_SCAN / OUT_POINTS + 2);
   localparam int ACC_W   = $clog2(OUT_POINTS);
   localparam int DBL_W   = SCAN_W + 1;
   localparam int SHIFT   = DBL_W + $clog2(OUT_POINTS);
   localparam int MULT_W  = DBL_W + 2;
   localparam int PROD_W  = DBL_W + MULT_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(OUT_POINTS) - 64'd1) / 64'(OUT_POINTS);
   localparam logic [MULT_W-1:0] RECIP = MULT_W'(RECIP_FULL);
   localparam logic [SCAN_W:0]   POINTS_CMP = (SCAN_W + 1)'(OUT_POINTS);
   localparam logic [DBL_W-1:0]  POINTS_DBL = DBL_W'(OUT_POINTS);

   logic [SCAN_W-1:0]   scan_length_ff, scan_length_in;
   logic [SCAN_W-1:0]   count_ff, count_in;
   logic                pass_ff, pass_in;
   logic [DBL_W-1:0]    dbl_ff, dbl_in;
   logic [DBL_W-1:0]    dbl2_ff, dbl2_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [LEN_W-1:0]    base_ff, base_in;
   logic [ACC_W-1:0]    inc_ff, inc_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   // register write
   always_comb begin
      scan_length_in = csr_wen ? csr_wdata : scan_length_ff;
   end

   // saturate to the ceiling
   always_comb begin
      if (int'(scan_length_ff) > MAX_SCAN) begin
         count_in = SCAN_W'(MAX_SCAN);
      end else begin
         count_in = scan_length_ff;
      end
   end

   // doubled count times reciprocal, mode flag
   always_comb begin
      dbl_in  = {count_ff, 1'b0};
      prod_in = PROD_W'(dbl_in) * PROD_W'(RECIP);
      pass_in = {1'b0, count_ff} < POINTS_CMP;
   end

   // quotient from the product, remainder from the quotient
   always_comb begin
      base_in = LEN_W'(prod_ff >> SHIFT);
      dbl2_in = dbl_ff;
      inc_in  = ACC_W'(dbl2_ff - DBL_W'(DBL_W'(base_ff) * POINTS_DBL));
   end

   // settle count after reset or a write
   always_comb begin
      if (csr_wen) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_length_ff <= SCAN_LENGTH_RST;
         settle_ff      <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         scan_length_ff <= scan_length_in;
         settle_ff      <= settle_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      pass_ff  <= pass_in;
      dbl_ff   <= dbl_in;
      prod_ff  <= prod_in;
      base_ff  <= base_in;
      dbl2_ff  <= dbl2_in;
      inc_ff   <= inc_in;
   end

   assign pass_mode   = pass_ff;
   assign scan_count  = count_ff;
   assign base_length = base_ff;
   assign step_inc    = inc_ff;
   assign cfg_ready   = (settle_ff == '0);

endmodule

// ----- hdl/mmd_window.sv -----
// -----------------------------------------------------------------------------
// mmd_window
// Input register and per-sample window logic: pass-through or min/max tracking
// over Bresenham-sized windows, handing zero, one or two results per sample.
// -----------------------------------------------------------------------------
module mmd_window #(
   parameter int OUT_POINTS = mmd_pkg::OUT_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mmd_pkg::SAMPLE_W-1:0]  req_tdata,
   input  logic                          pass_mode,
   input  logic [mmd_pkg::SCAN_W-1:0]    scan_count,
   input  logic [$clog2(2 * mmd_pkg::MAX_SCAN / OUT_POINTS + 2)-1:0] base_length,
   input  logic [$clog2(OUT_POINTS)-1:0] step_inc,
   input  logic                          cfg_ready,
   input  logic                          room,
   output mmd_pkg::rsp_push_type         push
);
   import mmd_pkg::*;

   localparam int LEN_W = $clog2(2 * MAX_SCAN / OUT_POINTS + 2);
   localparam int ACC_W = $clog2(OUT_POINTS);
   localparam logic [ACC_W:0] POINTS_SUM = (ACC_W + 1)'(OUT_POINTS);

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       advance;

   logic [SCAN_W-1:0]          pos_ff, pos_in;
   logic [LEN_W-1:0]           fill_ff, fill_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in;
   logic [LEN_W-1:0]           lo_slot_ff, lo_slot_in;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic [LEN_W-1:0]           hi_slot_ff, hi_slot_in;

   logic                       last;
   logic [SCAN_W-1:0]          pos_inc;
   logic [ACC_W:0]             acc_sum;
   logic [LEN_W-1:0]           fill_next;
   rsp_item_type               lo_item;
   rsp_item_type               hi_item;

   // input register handshake
   assign advance     = s1_valid_ff && room && cfg_ready;
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_sample_ff <= $signed(req_tdata);
      end
   end

   // scan position helpers
   assign last      = ({1'b0, pos_ff} + (SCAN_W + 1)'(1)) >= {1'b0, scan_count};
   assign pos_inc   = pos_ff + SCAN_W'(1);
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, step_inc};
   assign fill_next = fill_ff + LEN_W'(1);

   // sample update and result selection
   always_comb begin
      pos_in     = pos_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      lo_in      = lo_ff;
      lo_slot_in = lo_slot_ff;
      hi_in      = hi_ff;
      hi_slot_in = hi_slot_ff;
      push.count  = PUSH_NONE;
      push.first  = '0;
      push.second = '0;
      lo_item     = '0;
      hi_item     = '0;
      if (advance) begin
         if (pass_mode) begin
            // short scan: sample passes straight through
            push.count             = PUSH_ONE;
            push.first.value       = s1_sample_ff;
            push.first.end_of_run  = 1'b1;
            push.first.scan_done   = last;
            pos_in = last ? '0 : pos_inc;
         end else begin
            if (fill_ff == '0) begin
               // window start: size it and seed min/max
               if (acc_sum >= POINTS_SUM) begin
                  acc_in = ACC_W'(acc_sum - POINTS_SUM);
                  len_in = base_length + LEN_W'(1);
               end else begin
                  acc_in = acc_sum[ACC_W-1:0];
                  len_in = base_length;
               end
               lo_in      = s1_sample_ff;
               hi_in      = s1_sample_ff;
               lo_slot_in = '0;
               hi_slot_in = '0;
            end else begin
               // first occurrence wins on ties
               if (s1_sample_ff < lo_ff) begin
                  lo_in      = s1_sample_ff;
                  lo_slot_in = fill_ff;
               end
               if (s1_sample_ff > hi_ff) begin
                  hi_in      = s1_sample_ff;
                  hi_slot_in = fill_ff;
               end
            end

            lo_item.value = lo_in;
            hi_item.value = hi_in;

            if ((fill_next >= len_in) || last) begin
               // window closed: emit min and max in sample order
               push.count = PUSH_TWO;
               if (hi_slot_in < lo_slot_in) begin
                  push.first  = hi_item;
                  push.second = lo_item;
               end else begin
                  push.first  = lo_item;
                  push.second = hi_item;
               end
               push.first.end_of_run  = 1'b0;
               push.first.scan_done   = 1'b0;
               push.second.end_of_run = 1'b1;
               push.second.scan_done  = last;
               fill_in = '0;
               if (last) begin
                  pos_in = '0;
                  acc_in = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end else begin
               fill_in = fill_next;
               pos_in  = pos_inc;
            end
         end
      end
   end

   // scan and window state, cleared by reset or a register write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pos_ff     <= '0;
         fill_ff    <= '0;
         len_ff     <= '0;
         acc_ff     <= '0;
         lo_ff      <= '0;
         lo_slot_ff <= '0;
         hi_ff      <= '0;
         hi_slot_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         acc_ff     <= acc_in;
         lo_ff      <= lo_in;
         lo_slot_ff <= lo_slot_in;
         hi_ff      <= hi_in;
         hi_slot_ff <= hi_slot_in;
      end
   end

endmodule

// ----- hdl/mmd_out_fifo.sv -----
// -----------------------------------------------------------------------------
// mmd_out_fifo
// Four-entry result queue: takes up to two results a cycle from the window
// logic while it has room, and hands out one result a cycle as the output accepts.
// -----------------------------------------------------------------------------
module mmd_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  mmd_pkg::rsp_push_type push,
   output logic                  room,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mmd_pkg::rsp_item_type rsp_item
);
   import mmd_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_item   = mem[rd_ptr_ff];
   // a pair always fits when at most two entries are held
   assign room       = (count_ff <= CNT_W'(DEPTH - 2));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == PUSH_TWO) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

// ----- tb/min_max_decimator_checker.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// min_max_decimator_checker
// Watches the sample, result and scan_length ports of the min/max decimator.
// A model of the scan holds its own copy of the scan state and queues the
// results that each sample transfer should cause. Each result transfer is
// compared field by field with the oldest queued result.
// -----------------------------------------------------------------------------
module min_max_decimator_checker #(
   parameter int OUT_POINTS = mmd_pkg::OUT_POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,   // [15:0] sample
   // result channel
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [15:0]                rsp_tdata,   // [15:0] value
   input  logic                       rsp_tlast,   // end_of_run
   input  logic                       rsp_tuser,   // [0] scan_done
   // scan_length register
   input  logic                       csr_wen,
   input  logic [mmd_pkg::SCAN_W-1:0] csr_wdata,
   // status for the testbench top
   output int                         fail_count,
   output int                         pending_count,
   output int                         result_count
);

   import mmd_pkg::*;

   // mismatch lines printed before going quiet
   localparam int REPORT_LINES = 40;

   // results still to come out, oldest first
   rsp_item_type window_results_q[$];

   // scan model state
   logic [SCAN_W-1:0]          scan_len;
   logic [SCAN_W-1:0]          scan_pos;
   logic [4:0]                 win_fill;
   logic [4:0]                 win_len;
   logic [8:0]                 step_acc;
   logic signed [SAMPLE_W-1:0] low_val;
   logic signed [SAMPLE_W-1:0] high_val;
   logic [4:0]                 low_slot;
   logic [4:0]                 high_slot;

   int mismatches = 0;
   int results    = 0;

   // scan restart, as after reset or a register write
   task automatic restart_scan();
      scan_pos  = '0;
      win_fill  = '0;
      win_len   = '0;
      step_acc  = '0;
      low_val   = '0;
      high_val  = '0;
      low_slot  = '0;
      high_slot = '0;
   endtask

   // advance the scan by one sample and queue the results it causes
   task automatic decimate_sample(input logic signed [SAMPLE_W-1:0] s);
      int           count;
      int           base;
      int           inc;
      int           acc_sum;
      bit           last;
      rsp_item_type first;
      rsp_item_type second;
      count = (int'(scan_len) > MAX_SCAN) ? MAX_SCAN : int'(scan_len);
      last  = (int'(scan_pos) + 1) >= count;
      if (count < OUT_POINTS) begin
         // short scan: sample passes through
         first.value      = s;
         first.end_of_run = 1'b1;
         first.scan_done  = last;
         window_results_q.push_back(first);
         scan_pos = last ? '0 : scan_pos + 1'b1;
      end else begin
         base = (2 * count) / OUT_POINTS;
         inc  = 2 * count - base * OUT_POINTS;
         if (win_fill == '0) begin
            // window start: size from the accumulator
            acc_sum = int'(step_acc) + inc;
            if (acc_sum >= OUT_POINTS) begin
               step_acc = 9'(acc_sum - OUT_POINTS);
               win_len  = 5'(base + 1);
            end else begin
               step_acc = 9'(acc_sum);
               win_len  = 5'(base);
            end
            low_val   = s;
            high_val  = s;
            low_slot  = '0;
            high_slot = '0;
         end else begin
            // first occurrence wins on ties
            if (s < low_val) begin
               low_val  = s;
               low_slot = win_fill;
            end
            if (s > high_val) begin
               high_val  = s;
               high_slot = win_fill;
            end
         end
         win_fill = win_fill + 1'b1;
         if (win_fill >= win_len || last) begin
            // window closed: min and max in sample order
            if (high_slot < low_slot) begin
               first.value  = high_val;
               second.value = low_val;
            end else begin
               first.value  = low_val;
               second.value = high_val;
            end
            first.end_of_run  = 1'b0;
            first.scan_done   = 1'b0;
            second.end_of_run = 1'b1;
            second.scan_done  = last;
            window_results_q.push_back(first);
            window_results_q.push_back(second);
            win_fill = '0;
            if (last) begin
               scan_pos = '0;
               step_acc = '0;
            end else begin
               scan_pos = scan_pos + 1'b1;
            end
         end else begin
            scan_pos = scan_pos + 1'b1;
         end
      end
   endtask

   // one line per mismatch for the first REPORT_LINES, all counted
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < REPORT_LINES)
         $display("mismatch at result %0d: %s got %0d, expected %0d", results, what, got, want);
      mismatches++;
   endtask

   // follow register writes and transfers at each rising edge
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         scan_len = SCAN_LENGTH_RST;
         restart_scan();
         window_results_q.delete();
      end else begin
         if (csr_wen) begin
            scan_len = csr_wdata;
            restart_scan();
         end
         if (req_tvalid && req_tready)
            decimate_sample($signed(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (window_results_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected, value",
                               $signed(rsp_tdata), 0);
            end else begin
               want = window_results_q.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", $signed(rsp_tdata), want.value);
               if (rsp_tlast !== want.end_of_run)
                  report_mismatch("end_of_run", rsp_tlast, want.end_of_run);
               if (rsp_tuser !== want.scan_done)
                  report_mismatch("scan_done", rsp_tuser, want.scan_done);
            end
            results++;
         end
      end
      pending_count <= window_results_q.size();
      fail_count    <= mismatches;
      result_count  <= results;
   end

endmodule

// ----- tb/min_max_decimator_top_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// min_max_decimator_top_tb
// Drives signed samples into the min/max decimator over a series of scan
// lengths: pass-through scans, two-sample windows, uneven window sizes and the
// longest scan. Sender bursts and receiver stalls are random; the checker
// beside the block predicts every result and counts mismatches.
// -----------------------------------------------------------------------------
module min_max_decimator_top_tb;

   import mmd_pkg::*;

   localparam int IDLE_LIMIT   = 2000;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 16;     // quiet cycles once nothing is expected
   localparam int HOLD_AFTER   = 300;    // results taken before the long hold
   localparam int HOLD_CYCLES  = 400;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [15:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_wen;
   logic [SCAN_W-1:0]    csr_wdata;

   int fail_count;
   int pending_count;
   int result_count;

   int          samples_sent  = 0;
   int          settings_used = 0;
   int          burst_left    = 0;
   logic [15:0] prev_sample   = '0;

   always #5 clock = ~clock;

   min_max_decimator_top #(
      .OUT_POINTS (OUT_POINTS_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   min_max_decimator_checker #(
      .OUT_POINTS (OUT_POINTS_DEF)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // sample mix: full range, extremes, near-equal values and repeats
   function automatic logic [15:0] pick_sample();
      int          roll;
      logic [15:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         v = 16'($urandom);
      end else if (roll < 65) begin
         case ($urandom_range(0, 3))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            default: v = 16'hffff;
         endcase
      end else if (roll < 90) begin
         v = 16'($urandom_range(0, 4)) - 16'd2;
      end else begin
         v = prev_sample;
      end
      return v;
   endfunction

   // one sample transfer, then maybe a gap before the next burst
   task automatic push_sample(input logic [15:0] v);
      req_tdata  <= v;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      prev_sample = v;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 9) >= 4) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // stop sending until every queued result is out and the pipe is quiet
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // scan_length write while the block is idle
   task automatic write_scan_length(input int len);
      settle_idle();
      csr_wdata <= SCAN_W'(len);
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      settings_used++;
   endtask

   task automatic run_scan(input int len, input int n);
      write_scan_length(len);
      repeat (n) push_sample(pick_sample());
   endtask

   // receiver: rotating stall pattern, one long hold to back up the input
   initial begin : sink
      int taken;
      int cyc;
      bit held;
      bit ready;
      taken = 0;
      cyc   = 0;
      held  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready && !reset)
            taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            // always ready, coin flip, one in three, mostly ready
            case ((cyc / 97) % 4)
               0:       ready = 1'b1;
               1:       ready = $urandom_range(0, 1);
               2:       ready = (cyc % 3) == 0;
               default: ready = $urandom_range(0, 3) != 0;
            endcase
            rsp_tready <= ready;
         end
      end
   end

   // watchdog on cycles with no transfer at all
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [15:0] window_pairs [0:15];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default length gives two-sample windows: rising, falling, equal pairs
      window_pairs = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                       16'h0005, 16'h0005, 16'h0000, 16'hffff,
                       16'hffff, 16'h0000, 16'h7fff, 16'h7fff,
                       16'h8000, 16'h8000, 16'h0001, 16'hfffe};
      foreach (window_pairs[i])
         push_sample(window_pairs[i]);

      // zero length acts as one-sample scans
      write_scan_length(0);
      push_sample(16'h8000);
      push_sample(16'h7fff);
      write_scan_length(1);
      push_sample(16'h1234);
      push_sample(16'hffff);

      // random scans: pass-through, exact fit, uneven windows, longest scan
      run_scan(1, 40);
      run_scan(2, 40);
      run_scan(OUT_POINTS_DEF - 1, 410);
      run_scan(OUT_POINTS_DEF, 410);
      run_scan(OUT_POINTS_DEF + 1, 410);
      run_scan($urandom_range(OUT_POINTS_DEF + 2, 1200), 250);
      run_scan(MAX_SCAN, 250);
      run_scan($urandom_range(3, OUT_POINTS_DEF - 2), 120);
      run_scan(0, 40);

      settle_idle();
      $display("covered %0d samples and %0d results over %0d scan length writes",
               samples_sent, result_count, settings_used);
      $display("lengths from zero to %0d, pass-through and min/max windows", MAX_SCAN);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
